>>> rtl/rbd_pkg.sv
`timescale 1ns / 1ps

package rbd_pkg;

	localparam int RBD_DEPTH  = 16;
	localparam int WORD_W     = 32;
	localparam int COUNT_W    = 5;
	localparam int ACTION_W   = 2;
	localparam int STATUS_W   = 2;

	// all ones: what front and back read as on an empty queue
	localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_BACK  = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_BACK   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// what a whole chain does this cycle
	typedef enum logic [1:0] {
		CH_HOLD,
		CH_INSERT_HEAD,
		CH_REMOVE_HEAD,
		CH_APPEND
	} chain_op_t;

	// what one cell does this cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT,
		CELL_LOAD
	} cell_cmd_t;

	typedef struct packed {
		chain_op_t               op;
		logic signed [WORD_W-1:0] value;
	} chain_ctrl_t;

endpackage

>>> rtl/rbd_cell.sv
`timescale 1ns / 1ps

module rbd_cell
	import rbd_pkg::*;
(
	input  logic                     clk,
	input  cell_cmd_t                cmd,
	input  logic signed [WORD_W-1:0] load_data,
	input  logic signed [WORD_W-1:0] left_data,
	input  logic signed [WORD_W-1:0] right_data,
	output logic signed [WORD_W-1:0] data
);

	logic signed [WORD_W-1:0] data_q;

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		case (cmd)
			CELL_FROM_LEFT:  data_q <= left_data;
			CELL_FROM_RIGHT: data_q <= right_data;
			CELL_LOAD:       data_q <= load_data;
			default:         data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

>>> rtl/rbd_chain.sv
`timescale 1ns / 1ps

module rbd_chain
	import rbd_pkg::*;
#(
	parameter int DEPTH = RBD_DEPTH,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  chain_ctrl_t              ctrl,
	input  logic [CNT_W-1:0]         count,
	output logic signed [WORD_W-1:0] head_data
);

	logic signed [WORD_W-1:0] cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_cmd_t                cmd;
		logic signed [WORD_W-1:0] left_d;
		logic signed [WORD_W-1:0] right_d;

		// cell 0 takes the new word on an insert; the tail cell keeps its own
		if (i == 0) begin : g_first
			assign left_d = ctrl.value;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		always_comb begin
			case (ctrl.op)
				CH_INSERT_HEAD: cmd = CELL_FROM_LEFT;
				CH_REMOVE_HEAD: cmd = CELL_FROM_RIGHT;
				CH_APPEND:      cmd = (count == CNT_W'(i)) ? CELL_LOAD : CELL_HOLD;
				default:        cmd = CELL_HOLD;
			endcase
		end

		rbd_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.load_data  (ctrl.value),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i])
		);
	end

	assign head_data = cell_data[0];

endmodule

>>> rtl/ring_buffer_deque.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake              Payload
// input    in   in_valid / in_ready    action, value
// output   out  out_valid / out_ready  front_value, back_value, is_empty, entry_count, status
//
// One item per cycle if the output keeps up: a taken item moves the chains it needs; its result
// shows from the state registers on the next cycle. Throughput is set by the result register:
// a new item is taken whenever the result slot is empty or being taken in the same cycle.
// Reset clears the entry count, status and result slot; cell contents are left undefined and are
// only read once a push has filled them.
// A stall on the output side holds in_ready low, so state and result stay put.

module ring_buffer_deque
	import rbd_pkg::*;
#(
	parameter int DEPTH = RBD_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [ACTION_W-1:0]       action,
	input  logic signed [WORD_W-1:0]  value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [WORD_W-1:0]  front_value,
	output logic signed [WORD_W-1:0]  back_value,
	output logic                      is_empty,
	output logic [COUNT_W-1:0]        entry_count,
	output logic [STATUS_W-1:0]       status
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	// The deque is kept twice, as two rows of cells. The front chain holds the
	// entries front first, the back chain holds them back first, so both ends
	// always sit in cell 0 of a chain. A push at one end shifts that end's chain
	// and appends to the far end of the other; a pop at one end shifts that
	// end's chain and just drops the tail of the other via the count.

	logic [CNT_W-1:0]         count_q;
	status_t                  status_q;
	logic                     out_valid_q;

	logic                     in_fire;
	action_t                  act;
	logic                     full;
	logic                     empty;
	status_t                  step_status;
	logic [CNT_W-1:0]         count_next;
	chain_ctrl_t              front_ctrl;
	chain_ctrl_t              back_ctrl;
	logic signed [WORD_W-1:0] front_head;
	logic signed [WORD_W-1:0] back_head;
	logic [CNT_W+COUNT_W-1:0] count_ext;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign act      = action_t'(action);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	// step decode: chain commands, status and new count
	always_comb begin
		front_ctrl.op    = CH_HOLD;
		front_ctrl.value = value;
		back_ctrl.op     = CH_HOLD;
		back_ctrl.value  = value;
		step_status      = ST_DONE;
		count_next       = count_q;
		case (act)
			ACT_PUSH_FRONT: begin
				if (full) begin
					step_status = ST_FULL;
				end else begin
					front_ctrl.op = CH_INSERT_HEAD;
					back_ctrl.op  = CH_APPEND;
					count_next    = count_q + CNT_W'(1);
				end
			end
			ACT_PUSH_BACK: begin
				if (full) begin
					step_status = ST_FULL;
				end else begin
					back_ctrl.op  = CH_INSERT_HEAD;
					front_ctrl.op = CH_APPEND;
					count_next    = count_q + CNT_W'(1);
				end
			end
			ACT_POP_FRONT: begin
				if (empty) begin
					step_status = ST_EMPTY;
				end else begin
					front_ctrl.op = CH_REMOVE_HEAD;
					count_next    = count_q - CNT_W'(1);
				end
			end
			ACT_POP_BACK: begin
				if (empty) begin
					step_status = ST_EMPTY;
				end else begin
					back_ctrl.op = CH_REMOVE_HEAD;
					count_next   = count_q - CNT_W'(1);
				end
			end
			default: begin
				step_status = ST_DONE;
			end
		endcase
		// chains only move on an accepted item
		if (!in_fire) begin
			front_ctrl.op = CH_HOLD;
			back_ctrl.op  = CH_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			status_q    <= ST_DONE;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				count_q  <= count_next;
				status_q <= step_status;
			end
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	rbd_chain #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_front_chain (
		.clk       (clk),
		.ctrl      (front_ctrl),
		.count     (count_q),
		.head_data (front_head)
	);

	rbd_chain #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_back_chain (
		.clk       (clk),
		.ctrl      (back_ctrl),
		.count     (count_q),
		.head_data (back_head)
	);

	// result reads straight off the state; the count field wraps to its width
	assign count_ext   = {{COUNT_W{1'b0}}, count_q};
	assign out_valid   = out_valid_q;
	assign front_value = empty ? EMPTY_WORD : front_head;
	assign back_value  = empty ? EMPTY_WORD : back_head;
	assign is_empty    = empty;
	assign entry_count = count_ext[COUNT_W-1:0];
	assign status      = status_q;

	// count never passes the depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// a taken item that is refused (full or empty) leaves the count alone
	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (step_status != ST_DONE) |=> count_q == $past(count_q))
		else $error("rejected item changed count");

	// a taken push adds exactly one entry
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !full && ((act == ACT_PUSH_FRONT) || (act == ACT_PUSH_BACK))
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("push did not add one entry");

	// a pop-on-empty status always comes with an empty queue
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_EMPTY) |-> empty)
		else $error("empty status on non-empty queue");

endmodule
